>>> design/stsvf_pkg.sv
// Shared constants for the stereo trapezoidal state-variable filter.
`default_nettype none

package stsvf_pkg;

    // Configuration register file
    localparam int REG_W     = 32;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int HALF_W    = 16;

    // Base index of each coefficient set; the set's high lanes sit at base + 1
    localparam int REG_IN_LO  = 0;
    localparam int REG_ONE_LO = 2;
    localparam int REG_TWO_LO = 4;

    // Coefficients are Q3.F; state carries eight fraction bits below a sample LSB
    localparam int INT_BITS    = 3;
    localparam int STATE_EXTRA = 8;

endpackage

`default_nettype wire

>>> design/stsvf_channel.sv
// One channel of the filter: lane sums, state update and output rounding.
`default_nettype none

module stsvf_channel #(
    parameter int SAMPLE_BITS = 24,
    parameter int CW          = 16
) (
    input  logic signed [SAMPLE_BITS-1:0]                      i_sample,
    input  logic signed [SAMPLE_BITS+stsvf_pkg::STATE_EXTRA-1:0] i_s1,
    input  logic signed [SAMPLE_BITS+stsvf_pkg::STATE_EXTRA-1:0] i_s2,
    input  logic signed [CW-1:0]                               i_gain_in  [3],
    input  logic signed [CW-1:0]                               i_gain_one [3],
    input  logic signed [CW-1:0]                               i_gain_two [3],
    output logic signed [SAMPLE_BITS+stsvf_pkg::STATE_EXTRA-1:0] o_s1,
    output logic signed [SAMPLE_BITS+stsvf_pkg::STATE_EXTRA-1:0] o_s2,
    output logic signed [SAMPLE_BITS-1:0]                      o_out,
    output logic                                               o_clip
);

    localparam int SB     = SAMPLE_BITS + stsvf_pkg::STATE_EXTRA;
    localparam int F      = CW - stsvf_pkg::INT_BITS;
    localparam int PROD_W = CW + SB;
    localparam int ACC_W  = CW + SB + 2;

    // Slot 0 feeds state one, slot 1 state two, slot 2 the output
    localparam int SLOT_S1  = 0;
    localparam int SLOT_S2  = 1;
    localparam int SLOT_OUT = 2;

    localparam logic signed [ACC_W-1:0] HALF_STATE = ACC_W'(1) <<< (F - 1);
    localparam logic signed [ACC_W-1:0] HALF_OUT   = ACC_W'(1) <<< (F + stsvf_pkg::STATE_EXTRA - 1);
    localparam logic signed [ACC_W-1:0] S_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;
    localparam logic signed [ACC_W-1:0] O_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] O_MIN = ~O_MAX;

    logic signed [SB-1:0]     w_xs;
    logic signed [PROD_W-1:0] w_p_in  [3];
    logic signed [PROD_W-1:0] w_p_one [3];
    logic signed [PROD_W-1:0] w_p_two [3];
    logic signed [ACC_W-1:0]  w_sum   [3];
    logic signed [ACC_W-1:0]  w_d1;
    logic signed [ACC_W-1:0]  w_d2;
    logic signed [ACC_W-1:0]  w_q1;
    logic signed [ACC_W-1:0]  w_q2;
    logic signed [ACC_W-1:0]  w_qo;
    logic                     w_clip1;
    logic                     w_clip2;
    logic                     w_clipo;

    // Lift the sample into state units
    assign w_xs = {i_sample, {stsvf_pkg::STATE_EXTRA{1'b0}}};

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign w_p_in[k]  = i_gain_in[k]  * w_xs;
        assign w_p_one[k] = i_gain_one[k] * i_s1;
        assign w_p_two[k] = i_gain_two[k] * i_s2;
        assign w_sum[k]   = ACC_W'(w_p_in[k]) + ACC_W'(w_p_one[k]) + ACC_W'(w_p_two[k]);
    end

    // New state: lane sum less the old state, rounded half up
    assign w_d1 = w_sum[SLOT_S1] - (ACC_W'(i_s1) <<< F);
    assign w_d2 = w_sum[SLOT_S2] - (ACC_W'(i_s2) <<< F);
    assign w_q1 = (w_d1 + HALF_STATE) >>> F;
    assign w_q2 = (w_d2 + HALF_STATE) >>> F;
    assign w_qo = (w_sum[SLOT_OUT] + HALF_OUT) >>> (F + stsvf_pkg::STATE_EXTRA);

    always_comb begin
        w_clip1 = 1'b0;
        o_s1    = SB'(w_q1);
        if (w_q1 > S_MAX) begin
            w_clip1 = 1'b1;
            o_s1    = SB'(S_MAX);
        end else if (w_q1 < S_MIN) begin
            w_clip1 = 1'b1;
            o_s1    = SB'(S_MIN);
        end

        w_clip2 = 1'b0;
        o_s2    = SB'(w_q2);
        if (w_q2 > S_MAX) begin
            w_clip2 = 1'b1;
            o_s2    = SB'(S_MAX);
        end else if (w_q2 < S_MIN) begin
            w_clip2 = 1'b1;
            o_s2    = SB'(S_MIN);
        end

        w_clipo = 1'b0;
        o_out   = SAMPLE_BITS'(w_qo);
        if (w_qo > O_MAX) begin
            w_clipo = 1'b1;
            o_out   = SAMPLE_BITS'(O_MAX);
        end else if (w_qo < O_MIN) begin
            w_clipo = 1'b1;
            o_out   = SAMPLE_BITS'(O_MIN);
        end
    end

    assign o_clip = w_clip1 | w_clip2 | w_clipo;

endmodule

`default_nettype wire

>>> design/stereo_trapezoidal_svf.sv
// Top level of the stereo trapezoidal state-variable filter.
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       to block   i_in_valid / o_in_stall     i_left_sample, i_right_sample
// out      from block o_out_valid / i_out_stall   o_left_out, o_right_out, o_clipped
// cfg      to block   i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One frame per cycle sustained while the output is not stalled. A frame accepted
// into the input register reaches the result register after one multiply-add-round
// pass. State recursion closes through that single pass, setting the clock limit.
// Synchronous active-low reset clears state, coefficients and both valid flags.
// A stall on the output holds the result register; the input register then fills
// and o_in_stall rises, so no request is lost.

module stereo_trapezoidal_svf #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input frames
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       i_right_sample,
    // filtered frames
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_left_out,
    output logic signed [SAMPLE_BITS-1:0]       o_right_out,
    output logic                                o_clipped,
    // coefficient writes
    input  logic                                i_cfg_we,
    input  logic [stsvf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stsvf_pkg::REG_W-1:0]         i_cfg_data
);

    // Only the low CW bits of each 16-bit half are used
    localparam int CW = (COEFF_BITS > stsvf_pkg::HALF_W) ? stsvf_pkg::HALF_W : COEFF_BITS;
    localparam int SB = SAMPLE_BITS + stsvf_pkg::STATE_EXTRA;

    // Coefficient registers
    logic [stsvf_pkg::REG_W-1:0] r_cfg [stsvf_pkg::NUM_REGS];

    // Input register
    logic                         r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_in;
    logic signed [SAMPLE_BITS-1:0] r_right_in;

    // Integrator state
    logic signed [SB-1:0] r_l_s1;
    logic signed [SB-1:0] r_l_s2;
    logic signed [SB-1:0] r_r_s1;
    logic signed [SB-1:0] r_r_s2;

    // Result register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;
    logic                          r_clipped;

    logic signed [CW-1:0] w_gain [3][4];

    logic signed [SB-1:0]          n_l_s1;
    logic signed [SB-1:0]          n_l_s2;
    logic signed [SB-1:0]          n_r_s1;
    logic signed [SB-1:0]          n_r_s2;
    logic signed [SAMPLE_BITS-1:0] n_left_out;
    logic signed [SAMPLE_BITS-1:0] n_right_out;
    logic                          w_l_clip;
    logic                          w_r_clip;
    logic                          w_accept;
    logic                          w_advance;

    // Unpack each register into two signed lane coefficients
    for (genvar s = 0; s < 3; s++) begin : g_set
        for (genvar k = 0; k < 4; k++) begin : g_lane
            localparam int BASE = (s == 0) ? stsvf_pkg::REG_IN_LO :
                                  (s == 1) ? stsvf_pkg::REG_ONE_LO : stsvf_pkg::REG_TWO_LO;
            localparam int SEL  = BASE + k / 2;
            assign w_gain[s][k] = r_cfg[SEL][stsvf_pkg::HALF_W * (k % 2) +: CW];
        end
    end

    // Advance the held frame when the result register is empty or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Left output takes lane 3, right output takes lane 2
    stsvf_channel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW)
    ) u_left (
        .i_sample   (r_left_in),
        .i_s1       (r_l_s1),
        .i_s2       (r_l_s2),
        .i_gain_in  ('{w_gain[0][0], w_gain[0][1], w_gain[0][3]}),
        .i_gain_one ('{w_gain[1][0], w_gain[1][1], w_gain[1][3]}),
        .i_gain_two ('{w_gain[2][0], w_gain[2][1], w_gain[2][3]}),
        .o_s1       (n_l_s1),
        .o_s2       (n_l_s2),
        .o_out      (n_left_out),
        .o_clip     (w_l_clip)
    );

    stsvf_channel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW)
    ) u_right (
        .i_sample   (r_right_in),
        .i_s1       (r_r_s1),
        .i_s2       (r_r_s2),
        .i_gain_in  ('{w_gain[0][0], w_gain[0][1], w_gain[0][2]}),
        .i_gain_one ('{w_gain[1][0], w_gain[1][1], w_gain[1][2]}),
        .i_gain_two ('{w_gain[2][0], w_gain[2][1], w_gain[2][2]}),
        .o_s1       (n_r_s1),
        .o_s2       (n_r_s2),
        .o_out      (n_right_out),
        .o_clip     (w_r_clip)
    );

    // Coefficients: drop writes to indexes past the register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < stsvf_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we && (32'(i_cfg_index) < stsvf_pkg::NUM_REGS)) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_l_s1      <= '0;
            r_l_s2      <= '0;
            r_r_s1      <= '0;
            r_r_s2      <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_l_s1      <= n_l_s1;
                r_l_s2      <= n_l_s2;
                r_r_s1      <= n_r_s1;
                r_r_s2      <= n_r_s2;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load the input on accept, the result on advance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left_in  <= i_left_sample;
            r_right_in <= i_right_sample;
        end
        if (w_advance) begin
            r_left_out  <= n_left_out;
            r_right_out <= n_right_out;
            r_clipped   <= w_l_clip | w_r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;
    assign o_clipped   = r_clipped;

endmodule

`default_nettype wire

>>> tb/stsvf_frame_checker.sv
// Scoreboard for the stereo trapezoidal state-variable filter: predicts and checks every frame.
`timescale 1ns / 1ps

module stsvf_frame_checker #(
    parameter int SAMPLE_W = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [SAMPLE_W-1:0]          i_left_sample,
    input  logic signed [SAMPLE_W-1:0]          i_right_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [SAMPLE_W-1:0]          i_left_out,
    input  logic signed [SAMPLE_W-1:0]          i_right_out,
    input  logic                                i_clipped,
    input  logic                                i_cfg_we,
    input  logic [stsvf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stsvf_pkg::REG_W-1:0]         i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int COEFF_FRAC     = stsvf_pkg::HALF_W - stsvf_pkg::INT_BITS;
    localparam int STATE_W        = SAMPLE_W + stsvf_pkg::STATE_EXTRA;
    localparam int OUT_SHIFT      = COEFF_FRAC + stsvf_pkg::STATE_EXTRA;
    localparam int LEFT_CH        = 0;
    localparam int RIGHT_CH       = 1;
    localparam int LEFT_OUT_LANE  = 3;
    localparam int RIGHT_OUT_LANE = 2;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       clipped;
    } t_filtered_frame;

    t_filtered_frame             expected_frames [$];
    logic [stsvf_pkg::REG_W-1:0] coeff_regs [stsvf_pkg::NUM_REGS];
    longint                      integ [2][2];   // [channel][integrator one, two]

    function automatic longint gain(int base, int lane);
        logic signed [stsvf_pkg::HALF_W-1:0] half;
        half = coeff_regs[base + lane / 2][stsvf_pkg::HALF_W * (lane % 2) +: stsvf_pkg::HALF_W];
        return longint'(half);
    endfunction

    // round half up, then drop the fraction bits
    function automatic longint round_to(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(longint v, int bits, inout bit clip);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Advance one channel's integrators and return the sum of the requested lane.
    function automatic longint filter_channel(int ch, longint x, int out_lane, inout bit clip);
        longint lane_sum [4];
        longint s1;
        longint s2;
        s1 = integ[ch][0];
        s2 = integ[ch][1];
        for (int k = 0; k < 4; k++) begin
            lane_sum[k] = gain(stsvf_pkg::REG_IN_LO, k) * (x <<< stsvf_pkg::STATE_EXTRA)
                        + gain(stsvf_pkg::REG_ONE_LO, k) * s1
                        + gain(stsvf_pkg::REG_TWO_LO, k) * s2;
        end
        integ[ch][0] = clamp(round_to(lane_sum[0] - (s1 <<< COEFF_FRAC), COEFF_FRAC),
                             STATE_W, clip);
        integ[ch][1] = clamp(round_to(lane_sum[1] - (s2 <<< COEFF_FRAC), COEFF_FRAC),
                             STATE_W, clip);
        return lane_sum[out_lane];
    endfunction

    always @(posedge i_clk) begin
        t_filtered_frame want;
        bit              clip;
        longint          left_sum;
        longint          right_sum;
        if (!i_rst_n) begin
            expected_frames.delete();
            foreach (coeff_regs[i]) coeff_regs[i] = '0;
            foreach (integ[c, s]) integ[c][s] = 0;
        end else begin
            if (i_cfg_we && i_cfg_index < stsvf_pkg::NUM_REGS) begin
                coeff_regs[i_cfg_index] = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected frame: left_out %0d, right_out %0d, clipped %0b",
                           i_left_out, i_right_out, i_clipped);
                    o_fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_left_out !== want.left) begin
                        $error("left_out: expected %0d, got %0d", want.left, i_left_out);
                        o_fail_count++;
                    end
                    if (i_right_out !== want.right) begin
                        $error("right_out: expected %0d, got %0d", want.right, i_right_out);
                        o_fail_count++;
                    end
                    if (i_clipped !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b", want.clipped, i_clipped);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                clip = 1'b0;
                left_sum  = filter_channel(LEFT_CH, longint'(i_left_sample), LEFT_OUT_LANE, clip);
                right_sum = filter_channel(RIGHT_CH, longint'(i_right_sample), RIGHT_OUT_LANE,
                                           clip);
                want.left    = SAMPLE_W'(clamp(round_to(left_sum, OUT_SHIFT), SAMPLE_W, clip));
                want.right   = SAMPLE_W'(clamp(round_to(right_sum, OUT_SHIFT), SAMPLE_W, clip));
                want.clipped = clip;
                expected_frames.push_back(want);
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

>>> tb/stereo_trapezoidal_svf_test.sv
// Top of the stereo trapezoidal state-variable filter testbench: stimulus and verdict.
`timescale 1ns / 1ps

module stereo_trapezoidal_svf_test;

    localparam int SAMPLE_W      = 24;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int QUIET_LIMIT   = 2000;   // cycles with no request moving on either side
    localparam int LONG_HOLD     = 64;     // receiver hold-off, long enough to back up the input
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES  = 160;
    localparam int SETTLE_CYCLES = 4;      // input register plus one filter pass, with margin
    localparam int HALF_W        = stsvf_pkg::HALF_W;
    localparam int CFG_IDX_W     = stsvf_pkg::CFG_IDX_W;
    localparam int NUM_REGS      = stsvf_pkg::NUM_REGS;
    localparam int UNITY_GAIN    = 1 << (HALF_W - stsvf_pkg::INT_BITS);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_left_sample;
    logic signed [SAMPLE_W-1:0]  i_right_sample;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [SAMPLE_W-1:0]  o_left_out;
    logic signed [SAMPLE_W-1:0]  o_right_out;
    logic                        o_clipped;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [stsvf_pkg::REG_W-1:0] i_cfg_data;

    int fail_count;
    int frames_pending;
    int quiet_cycles;

    // Idle odds: one gap every N requests on average; zero turns gaps off.
    int in_gap_odds;
    int out_gap_odds;
    bit long_hold_pending;

    // Register words staged here and then written as a block while the filter is idle.
    logic [stsvf_pkg::REG_W-1:0] coeff_plan [NUM_REGS];

    stereo_trapezoidal_svf #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_clipped      (o_clipped),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    stsvf_frame_checker #(
        .SAMPLE_W(SAMPLE_W)
    ) frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_left_out     (o_left_out),
        .i_right_out    (o_right_out),
        .i_clipped      (o_clipped),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (frames_pending)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: abort when neither channel has moved a request for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off when the stimulus asks for it.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (out_gap_odds != 0 && $urandom_range(1, out_gap_odds) == 1) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic void set_gain(int base, int lane, int value);
        coeff_plan[base + lane / 2][HALF_W * (lane % 2) +: HALF_W] = value[HALF_W-1:0];
    endfunction

    function automatic void clear_plan();
        foreach (coeff_plan[i]) coeff_plan[i] = '0;
    endfunction

    // Well-behaved filter: the integrator feedback has an infinity norm of at most 0.75,
    // so the state decays; input and output lanes get random gains up to unity.
    function automatic void plan_stable();
        set_gain(stsvf_pkg::REG_ONE_LO, 0, UNITY_GAIN + spread(UNITY_GAIN / 2));
        set_gain(stsvf_pkg::REG_TWO_LO, 0, spread(UNITY_GAIN / 4));
        set_gain(stsvf_pkg::REG_ONE_LO, 1, spread(UNITY_GAIN / 4));
        set_gain(stsvf_pkg::REG_TWO_LO, 1, UNITY_GAIN + spread(UNITY_GAIN / 2));
        set_gain(stsvf_pkg::REG_IN_LO, 0, spread(UNITY_GAIN / 4));
        set_gain(stsvf_pkg::REG_IN_LO, 1, spread(UNITY_GAIN / 4));
        for (int lane = 2; lane < 4; lane++) begin
            set_gain(stsvf_pkg::REG_IN_LO, lane, spread(UNITY_GAIN));
            set_gain(stsvf_pkg::REG_ONE_LO, lane, spread(UNITY_GAIN));
            set_gain(stsvf_pkg::REG_TWO_LO, lane, spread(UNITY_GAIN));
        end
    endfunction

    function automatic void plan_extreme();
        foreach (coeff_plan[i]) begin
            coeff_plan[i] = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000),
                             ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Write the staged words; optionally also hit the unused indexes, which must be ignored.
    // Call only while idle, at a falling edge.
    task automatic load_coeff_plan(bit with_spares);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[CFG_IDX_W-1:0];
            i_cfg_data  <= coeff_plan[i];
            @(negedge i_clk);
        end
        if (with_spares) begin
            for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= i[CFG_IDX_W-1:0];
                i_cfg_data  <= $urandom();
                @(negedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one frame, maybe after an idle burst, and hold it until it is taken.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
        if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every predicted frame to come out, then let the pipe settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (frames_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_left_sample     = '0;
        i_right_sample    = '0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        in_gap_odds       = 4;
        out_gap_odds      = 4;
        long_hold_pending = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset coefficients are all zero: full-scale input must give silence.
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        drain_results();

        // Unity pass-through on the output lanes; the spare indexes get junk.
        clear_plan();
        set_gain(stsvf_pkg::REG_IN_LO, 2, UNITY_GAIN);
        set_gain(stsvf_pkg::REG_IN_LO, 3, UNITY_GAIN);
        load_coeff_plan(1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN);
        send_frame('0, '0);
        send_frame(SAMPLE_W'(1), SAMPLE_W'(-1));
        send_frame(SAMPLE_W'(-1), SAMPLE_W'(1));
        drain_results();

        // Smallest gain: the first outputs land on exact halves, checking round half up both signs.
        clear_plan();
        set_gain(stsvf_pkg::REG_IN_LO, 2, 1);
        set_gain(stsvf_pkg::REG_IN_LO, 3, 1);
        load_coeff_plan(1'b0);
        send_frame(SAMPLE_W'(4096), SAMPLE_W'(-4096));
        send_frame(SAMPLE_W'(-4096), SAMPLE_W'(4096));
        send_frame(SAMPLE_W'(4095), SAMPLE_W'(-4097));
        send_frame(SAMPLE_W'(-4097), SAMPLE_W'(4095));
        drain_results();

        // Largest positive and negative gains: full-scale outputs saturate high and low.
        clear_plan();
        set_gain(stsvf_pkg::REG_IN_LO, 3, 16'h7FFF);
        set_gain(stsvf_pkg::REG_IN_LO, 2, 16'h8000);
        load_coeff_plan(1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN);
        send_frame(SAMPLE_W'(100), SAMPLE_W'(-100));
        drain_results();

        // Runaway integrators: state saturates at both ends.
        foreach (coeff_plan[i]) coeff_plan[i] = 32'h7FFF_7FFF;
        load_coeff_plan(1'b0);
        repeat (2) send_frame(SAMPLE_MAX, SAMPLE_MIN);
        repeat (2) send_frame(SAMPLE_MIN, SAMPLE_MAX);
        drain_results();
        foreach (coeff_plan[i]) coeff_plan[i] = 32'h8000_8000;
        load_coeff_plan(1'b0);
        repeat (2) send_frame(SAMPLE_MIN, SAMPLE_MAX);
        repeat (2) send_frame(SAMPLE_MAX, SAMPLE_MIN);
        drain_results();

        // Random phases: mostly stable filters, one with raw random words, one at the rails.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            clear_plan();
            if (phase == 3) begin
                foreach (coeff_plan[i]) coeff_plan[i] = $urandom();
            end else if (phase == 5) begin
                plan_extreme();
            end else begin
                plan_stable();
            end
            load_coeff_plan(1'b0);

            // Final phase runs flat out on both sides.
            in_gap_odds  = (phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(2, 12);
            out_gap_odds = (phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(2, 12);

            // Back the pipe up: receiver holds off while the sender keeps offering.
            if (phase == 2) begin
                in_gap_odds       = 0;
                long_hold_pending = 1'b1;
            end

            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (phase == 2 && n == 40) in_gap_odds = $urandom_range(2, 12);
                // Sender pause in mid-stream until every result is out.
                if (phase == 4 && n == PHASE_FRAMES / 2) drain_results();
                send_frame(random_sample(), random_sample());
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
